// ----- rtl/core/stcd_pkg.sv -----
// Shared types and constants for the spike threshold crossing detector.
package stcd_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int LIMIT_WIDTH     = 17;
   localparam int RSP_INDEX_WIDTH = 32;
   localparam int INDEX_WIDTH_MAX = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 17;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_LIMIT = 2'd1;

   // Reset values of the configuration registers.
   localparam logic signed [SAMPLE_WIDTH-1:0] THRESHOLD_RESET   = -16'sd16384;
   localparam logic signed [LIMIT_WIDTH-1:0]  UPPER_LIMIT_RESET = 17'sd32768;

   // An upper limit at or above this level turns the amplitude reject off.
   localparam logic signed [LIMIT_WIDTH-1:0]  LIMIT_DISABLE = 17'sd32767;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last;
   } stcd_item_type;

   typedef struct packed {
      logic                       hit;
      logic [RSP_INDEX_WIDTH-1:0] index;
   } stcd_result_type;

endpackage

// ----- rtl/core/stcd_detect.sv -----
// Crossing detection state machine: arming, candidate tracking and sample counting.
module stcd_detect
   import stcd_pkg::*;
#(
   parameter int INDEX_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  stcd_item_type                  item,
   input  logic signed [SAMPLE_WIDTH-1:0] threshold,
   input  logic signed [LIMIT_WIDTH-1:0]  upper_limit,
   output stcd_result_type                result
);

   logic                   armed_ff, armed_in;
   logic                   pending_ff, pending_in;
   logic [INDEX_WIDTH-1:0] pending_index_ff, pending_index_in;
   logic [INDEX_WIDTH-1:0] counter_ff, counter_in;

   logic signed [LIMIT_WIDTH-1:0] sample_ext;
   logic                          below;
   logic                          above;
   logic                          over_limit;
   logic                          limit_off;
   logic                          fire;
   logic                          reject;
   logic                          accept_pending;
   logic                          accept_now;
   logic                          new_pending;
   logic [INDEX_WIDTH-1:0]        sel_index;
   logic [INDEX_WIDTH_MAX-1:0]    sel_wide;

   always_comb begin
      sample_ext     = LIMIT_WIDTH'(item.sample);
      below          = item.sample < threshold;
      above          = item.sample > threshold;
      over_limit     = sample_ext > upper_limit;
      limit_off      = upper_limit >= LIMIT_DISABLE;
      fire           = above && armed_ff;
      reject         = pending_ff && over_limit;
      accept_pending = pending_ff && !over_limit && below;
      accept_now     = fire && limit_off;
      new_pending    = fire && !limit_off && !over_limit;

      sel_index    = accept_pending ? pending_index_ff : counter_ff;
      sel_wide     = INDEX_WIDTH_MAX'(sel_index);
      result.hit   = accept_pending || accept_now;
      result.index = sel_wide[RSP_INDEX_WIDTH-1:0];

      armed_in         = below ? 1'b1 : (fire ? 1'b0 : armed_ff);
      pending_in       = new_pending || (pending_ff && !reject && !accept_pending);
      pending_index_in = new_pending ? counter_ff : pending_index_ff;
      counter_in       = (&counter_ff) ? counter_ff
                         : counter_ff + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};

      if (item.last) begin
         armed_in         = 1'b0;
         pending_in       = 1'b0;
         pending_index_in = '0;
         counter_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= 1'b0;
         pending_ff       <= 1'b0;
         pending_index_ff <= '0;
         counter_ff       <= '0;
      end else if (advance) begin
         armed_ff         <= armed_in;
         pending_ff       <= pending_in;
         pending_index_ff <= pending_index_in;
         counter_ff       <= counter_in;
      end
   end

endmodule

// ----- rtl/core/stcd_out_stage.sv -----
// Result register that holds one crossing index until the receiver takes it.
module stcd_out_stage
   import stcd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [RSP_INDEX_WIDTH-1:0] load_index,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [RSP_INDEX_WIDTH-1:0] rsp_crossing_index
);

   logic                       valid_ff, valid_in;
   logic [RSP_INDEX_WIDTH-1:0] index_ff;

   always_comb begin
      free     = !valid_ff || rsp_ready;
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= load_index;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_crossing_index = index_ff;

endmodule

// ----- rtl/core/spike_threshold_crossing_detector.sv -----
// Top level of the spike threshold crossing detector.
//
// Samples arrive on the req_ channel (req_sample, req_last) with a valid/ready
// handshake; each transfer moves one signed sample. Accepted upward crossings
// leave on the rsp_ channel as rsp_crossing_index, the sample's index within
// its record. A sample marked by req_last ends the record: any candidate still
// waiting is dropped and the index counter starts again at zero.
//
// A transfer is first captured in an input register. In the following cycle
// the comparisons and flag updates run on it, and any crossing is written to
// the result register once it is free; rsp_valid is driven by that register.
// One sample is taken in every cycle while no crossing waits for a busy result
// register; that single register decides whether the input register may empty.
//
// When the receiver stalls with a result waiting, samples that produce no crossing
// keep flowing; the first sample that would produce a crossing waits in the input
// register until the result register is free, and req_ready then stays low. Reset
// (synchronous, active high) clears the detector state and both valid flags and
// loads the threshold and upper limit with their reset levels. The configuration
// registers are written via csr_write_enable, csr_index and csr_write_data by the
// user only while the block is idle (not enforced); other indexes are ignored.
module spike_threshold_crossing_detector
   import stcd_pkg::*;
#(
   parameter int INDEX_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_last,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [RSP_INDEX_WIDTH-1:0]     rsp_crossing_index,

   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_write_data
);

   // Configuration registers.
   logic signed [SAMPLE_WIDTH-1:0] threshold_ff;
   logic signed [LIMIT_WIDTH-1:0]  upper_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         upper_limit_ff <= UPPER_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_THRESHOLD: begin
               threshold_ff <= csr_write_data[SAMPLE_WIDTH-1:0];
            end
            REG_UPPER_LIMIT: begin
               upper_limit_ff <= csr_write_data[LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register.
   logic            in_valid_ff, in_valid_in;
   stcd_item_type   item_ff;
   stcd_result_type result;
   logic            out_free;
   logic            advance;
   logic            take;

   // The held sample moves on unless it produces a crossing and the result
   // register is still occupied.
   always_comb begin
      advance     = in_valid_ff && (!result.hit || out_free);
      req_ready   = !in_valid_ff || advance;
      take        = req_valid && req_ready;
      in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.sample <= req_sample;
         item_ff.last   <= req_last;
      end
   end

   stcd_detect #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_detect (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item_ff),
      .threshold   (threshold_ff),
      .upper_limit (upper_limit_ff),
      .result      (result)
   );

   stcd_out_stage u_out_stage (
      .clock              (clock),
      .reset              (reset),
      .load               (advance && result.hit),
      .load_index         (result.index),
      .free               (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_crossing_index (rsp_crossing_index)
   );

endmodule

// ----- sim/tb_spike_threshold_crossing_detector.sv -----
// Self-checking testbench for the spike threshold crossing detector.
`timescale 1ns / 1ps

module tb_spike_threshold_crossing_detector;
   import stcd_pkg::*;

   // Clocking and run control.
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   // Idle cycles that make sure a sample which causes no crossing has left the
   // pipeline before a register changes.
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDX_W         = 32;

   // The random part runs through a series of register settings, a fixed number of
   // samples under each one.
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 105;
   localparam int RANDOM_TOTAL  = RANDOM_PHASES * PHASE_SAMPLES;

   // Indexes that map to no register; writes to them must leave the detector alone.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   // One row of the directed stimulus. A sample row carries the sample in the low bits
   // of value; a register row carries the write data. Where typed is set, the row's
   // crossing index is written out by hand instead of being taken from the predictor.
   typedef struct {
      row_kind_type                kind;
      logic [CSR_DATA_WIDTH-1:0]   value;
      logic [CSR_INDEX_WIDTH-1:0]  reg_sel;
      logic                        last;
      bit                          typed;
      logic [RSP_INDEX_WIDTH-1:0]  typed_index;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic                          req_last;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [RSP_INDEX_WIDTH-1:0]    rsp_crossing_index;
   logic                          csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_write_data;

   // Predictor state: the register copies and the detector flags and counters.
   logic signed [SAMPLE_WIDTH-1:0] model_threshold;
   logic signed [LIMIT_WIDTH-1:0]  model_limit;
   logic                           armed_flag;
   logic                           pending_flag;
   logic [IDX_W-1:0]               pending_at;
   logic [IDX_W-1:0]               sample_position;

   // Crossing indexes still owed by the block, oldest first.
   logic [RSP_INDEX_WIDTH-1:0]     crossings_q[$];
   stim_row_type                   directed_rows[$];
   logic [RSP_INDEX_WIDTH-1:0]     oldest_crossing;

   int send_idle_pct;
   int ready_stall_pct;
   int mismatches        = 0;
   int crossings_checked = 0;
   int samples_sent      = 0;
   int records_closed    = 0;
   int settings_used     = 0;
   int cycle_count       = 0;

   spike_threshold_crossing_detector #(
      .INDEX_WIDTH(IDX_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_crossing_index (rsp_crossing_index),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Steps the detector predictor by one sample and reports whether it yields an
   // accepted crossing. A pending candidate is resolved first (reject wins over accept
   // when the sample is both above the limit and below the threshold), then the sample
   // may arm the detector or fire a new candidate, and a last sample closes the record.
   function automatic bit detect_crossing(input logic signed [SAMPLE_WIDTH-1:0] s,
                                          input logic l,
                                          output logic [RSP_INDEX_WIDTH-1:0] at);
      bit hit;
      hit = 1'b0;
      at  = '0;
      if (pending_flag) begin
         if (s > model_limit) begin
            pending_flag = 1'b0;
         end else if (s < model_threshold) begin
            hit          = 1'b1;
            at           = pending_at[RSP_INDEX_WIDTH-1:0];
            pending_flag = 1'b0;
         end
      end
      if (s < model_threshold) begin
         armed_flag = 1'b1;
      end else if (s > model_threshold && armed_flag) begin
         armed_flag = 1'b0;
         // With the reject check off the crossing is accepted on the spot; otherwise a
         // candidate already above the limit is thrown away and never waits.
         if (model_limit >= LIMIT_DISABLE) begin
            hit = 1'b1;
            at  = sample_position[RSP_INDEX_WIDTH-1:0];
         end else if (s <= model_limit) begin
            pending_flag = 1'b1;
            pending_at   = sample_position;
         end
      end
      // The index counter sticks at its top value instead of wrapping.
      if (sample_position != '1) begin
         sample_position++;
      end
      if (l) begin
         armed_flag      = 1'b0;
         pending_flag    = 1'b0;
         pending_at      = '0;
         sample_position = '0;
      end
      return hit;
   endfunction

   function automatic void set_model_register(input logic [CSR_INDEX_WIDTH-1:0] sel,
                                              input logic [CSR_DATA_WIDTH-1:0] data);
      case (sel)
         REG_THRESHOLD:   model_threshold = data[SAMPLE_WIDTH-1:0];
         REG_UPPER_LIMIT: model_limit     = data;
         default: ;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(input int v);
      if (v < -32768) begin
         return 16'sh8000;
      end else if (v > 32767) begin
         return 16'sd32767;
      end
      return v[SAMPLE_WIDTH-1:0];
   endfunction

   // Draws a sample around the current threshold and limit so that the detector keeps
   // arming, firing and resolving candidates. Most draws stay near the threshold, some
   // reach across the whole range, and a share are plain noise.
   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      int thr;
      int top;
      int reach;
      int span;
      int pick;
      thr   = int'(model_threshold);
      top   = (model_limit < LIMIT_DISABLE) ? int'(model_limit) : 32767;
      reach = ($urandom_range(0, 3) == 0) ? 40000 : 300;
      pick  = $urandom_range(0, 99);
      if (pick < 38) begin
         return clamp_sample(thr - int'($urandom_range(1, reach)));
      end else if (pick < 72) begin
         span = (top > thr) ? top - thr : reach;
         if (span > reach) begin
            span = reach;
         end
         return clamp_sample(thr + int'($urandom_range(1, span)));
      end else if (pick < 80) begin
         return model_threshold;
      end else if (pick < 88) begin
         return clamp_sample(top + int'($urandom_range(1, reach)));
      end
      return SAMPLE_WIDTH'($urandom);
   endfunction

   // Offers one sample, with an optional gap in front of it, and holds it until the
   // transfer. The sender stays idle in each cycle with the set percentage. The
   // predictor runs at the transfer edge; a typed row supplies its own expected index
   // instead of the predicted one.
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic l,
                              input bit typed,
                              input logic [RSP_INDEX_WIDTH-1:0] typed_index);
      logic [RSP_INDEX_WIDTH-1:0] at;
      bit                         hit;
      int                         gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= l;
      do @(posedge clock); while (!req_ready);
      hit = detect_crossing(s, l, at);
      if (typed) begin
         crossings_q.push_back(typed_index);
      end else if (hit) begin
         crossings_q.push_back(at);
      end
      samples_sent++;
      if (l) begin
         records_closed++;
      end
   endtask

   // Stops offering samples and waits until every expected crossing has come back and
   // the pipeline has had time to empty.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (crossings_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] sel,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      set_model_register(sel, data);
   endtask

   task automatic add_sample_row(input int s, input logic l, input bit typed,
                                 input logic [RSP_INDEX_WIDTH-1:0] typed_index);
      stim_row_type row;
      row.kind        = ROW_SAMPLE;
      row.value       = s[CSR_DATA_WIDTH-1:0];
      row.reg_sel     = REG_THRESHOLD;
      row.last        = l;
      row.typed       = typed;
      row.typed_index = typed_index;
      directed_rows.push_back(row);
   endtask

   task automatic add_csr_row(input logic [CSR_INDEX_WIDTH-1:0] sel, input int data);
      stim_row_type row;
      row.kind        = ROW_CSR;
      row.value       = data[CSR_DATA_WIDTH-1:0];
      row.reg_sel     = sel;
      row.last        = 1'b0;
      row.typed       = 1'b0;
      row.typed_index = '0;
      directed_rows.push_back(row);
   endtask

   // The receiver decides afresh at every falling edge whether it takes a result.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
   end

   // Every result transfer is matched against the oldest expected crossing.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (crossings_q.size() == 0) begin
            $display("%0t: unexpected crossing, expected none, actual index %0d",
                     $time, rsp_crossing_index);
            mismatches++;
         end else begin
            oldest_crossing = crossings_q.pop_front();
            if (rsp_crossing_index !== oldest_crossing) begin
               $display("%0t: crossing index mismatch, expected %0d, actual %0d",
                        $time, oldest_crossing, rsp_crossing_index);
               mismatches++;
            end
            crossings_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d crossings outstanding.",
                  cycle_count, crossings_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int                        thr_val;
      int                        lim_val;
      logic [CSR_DATA_WIDTH-1:0] thr_data;
      int                        drawn;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      req_last         = 1'b0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = REG_THRESHOLD;
      csr_write_data   = '0;
      model_threshold  = THRESHOLD_RESET;
      model_limit      = UPPER_LIMIT_RESET;
      armed_flag       = 1'b0;
      pending_flag     = 1'b0;
      pending_at       = '0;
      sample_position  = '0;
      send_idle_pct    = 27;
      ready_stall_pct  = 67;

      // Reset levels: threshold -16384 and the reject check off, so every crossing is
      // accepted on the sample that fires it. Full-scale samples, a sample equal to the
      // threshold and the end of a record are all exercised here.
      add_sample_row(0,      1'b0, 1'b0, '0);
      add_sample_row(-32768, 1'b0, 1'b0, '0);
      add_sample_row(32767,  1'b0, 1'b1, 32'd2);
      add_sample_row(-16385, 1'b0, 1'b0, '0);
      add_sample_row(-16384, 1'b0, 1'b0, '0);
      add_sample_row(-16383, 1'b0, 1'b1, 32'd5);
      add_sample_row(-20000, 1'b1, 1'b0, '0);
      // Threshold 0 with the reject check at 1000. Writes to unused indexes follow and
      // must not disturb either register.
      add_csr_row(REG_THRESHOLD,   0);
      add_csr_row(REG_UPPER_LIMIT, 1000);
      add_csr_row(REG_SPARE_2,     32'h1FFFF);
      add_csr_row(REG_SPARE_3,     0);
      // A candidate above the limit dies at once; a candidate in range waits through an
      // equal sample and a non-arming sample and is accepted by the next low sample.
      add_sample_row(-5,   1'b0, 1'b0, '0);
      add_sample_row(2000, 1'b0, 1'b0, '0);
      add_sample_row(-5,   1'b0, 1'b0, '0);
      add_sample_row(500,  1'b0, 1'b0, '0);
      add_sample_row(0,    1'b0, 1'b0, '0);
      add_sample_row(700,  1'b0, 1'b0, '0);
      add_sample_row(-1,   1'b0, 1'b1, 32'd3);
      // A waiting candidate is rejected by a later sample over the limit, and a
      // candidate that fires on the last sample of a record is dropped.
      add_sample_row(10,   1'b0, 1'b0, '0);
      add_sample_row(1001, 1'b0, 1'b0, '0);
      add_sample_row(-1,   1'b0, 1'b0, '0);
      add_sample_row(10,   1'b1, 1'b0, '0);
      // A candidate is left waiting, then the threshold moves above the limit, so the
      // resolving sample is over the limit and under the threshold at once: it rejects.
      add_sample_row(-5,   1'b0, 1'b0, '0);
      add_sample_row(10,   1'b0, 1'b0, '0);
      add_csr_row(REG_THRESHOLD, 2000);
      add_sample_row(1500, 1'b1, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      settings_used = 1;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            settings_used++;
         end else begin
            send_sample(directed_rows[i].value[SAMPLE_WIDTH-1:0], directed_rows[i].last,
                        directed_rows[i].typed, directed_rows[i].typed_index);
         end
      end
      wait_idle();

      // Random part. Each phase picks a register setting, among them both disable
      // boundaries of the limit and the extremes of both registers.
      drawn = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               thr_val = int'($urandom_range(0, 4000)) - 2000;
               lim_val = 32768;
            end
            1: begin
               thr_val = 0;
               lim_val = 32767;
            end
            2: begin
               thr_val = 0;
               lim_val = 32766;
            end
            3: begin
               thr_val = int'($urandom_range(0, 20000)) - 10000;
               lim_val = thr_val + int'($urandom_range(1, 3000));
            end
            4: begin
               thr_val = -32768;
               lim_val = -32768;
            end
            5: begin
               thr_val = 32767;
               lim_val = 32768;
            end
            6: begin
               thr_val = int'($urandom_range(0, 65535)) - 32768;
               lim_val = int'($urandom_range(0, 65536)) - 32768;
            end
            default: begin
               thr_val = int'($urandom_range(0, 600)) - 300;
               lim_val = thr_val + int'($urandom_range(0, 400)) - 200;
            end
         endcase
         thr_data = thr_val[CSR_DATA_WIDTH-1:0];
         // Bit 16 of a threshold write lies above the register and must be dropped.
         if (p == 6) begin
            thr_data[CSR_DATA_WIDTH-1] = 1'b1;
         end
         write_register(REG_THRESHOLD, thr_data);
         write_register(REG_UPPER_LIMIT, lim_val[CSR_DATA_WIDTH-1:0]);
         settings_used++;

         for (int k = 0; k < PHASE_SAMPLES; k++) begin
            // Sender mostly busy and receiver mostly stalled first, then the reverse,
            // then both at full rate.
            if (drawn < RANDOM_TOTAL / 3) begin
               send_idle_pct   = 27;
               ready_stall_pct = 67;
            end else if (drawn < 2 * RANDOM_TOTAL / 3) begin
               send_idle_pct   = 67;
               ready_stall_pct = 27;
            end else begin
               send_idle_pct   = 0;
               ready_stall_pct = 0;
            end
            send_sample(pick_sample(), ($urandom_range(0, 39) == 0), 1'b0, '0);
            drawn++;
         end
         wait_idle();
      end

      $display("Ran %0d samples in %0d closed records under %0d register settings.",
               samples_sent, records_closed, settings_used);
      $display("Checked %0d crossings across three stall patterns, %0d mismatches.",
               crossings_checked, mismatches);
      if (mismatches == 0 && crossings_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
